/* hdl/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg
// Shared sizes, command and status codes and the control bundle that drives
// the row of storage cells of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEPTH   = 16;
   localparam int WIDTH   = 32;
   localparam int DATA_W  = 32;
   localparam int STORE_W = (WIDTH < DATA_W) ? WIDTH : DATA_W;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_BACK  = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_BACK   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef logic [DATA_W-1:0]  data_type;
   typedef logic [STORE_W-1:0] word_type;
   typedef logic [COUNT_W-1:0] count_type;

   // at most one operation set, broadcast to every cell, already gated by full/empty
   typedef struct packed {
      logic push_front;
      logic push_back;
      logic pop_front;
      logic pop_back;
   } cell_ctrl_type;

endpackage

/* hdl/deq_req_if.sv */
// ----------------------------------------------------------------------------
// deq_req_if
// Command channel: valid/ready handshake with the command and the push word.
// ----------------------------------------------------------------------------
interface deq_req_if;
   logic               valid;
   logic               ready;
   deq_pkg::cmd_type   cmd;
   deq_pkg::data_type  data_in;

   modport source (output valid, output cmd, output data_in, input ready);
   modport sink   (input valid, input cmd, input data_in, output ready);
endinterface

/* hdl/deq_rsp_if.sv */
// ----------------------------------------------------------------------------
// deq_rsp_if
// Result channel: valid/ready handshake with popped word, status and count.
// ----------------------------------------------------------------------------
interface deq_rsp_if;
   logic                 valid;
   logic                 ready;
   deq_pkg::data_type    data_out;
   deq_pkg::status_type  status;
   deq_pkg::count_type   count;

   modport source (output valid, output data_out, output status, output count,
                   input ready);
   modport sink   (input valid, input data_out, input status, input count,
                   output ready);
endinterface

/* hdl/deq_cell.sv */
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the queue row. Holds a word and an occupied flag and
// shifts towards either neighbour on front pushes and front pops, and fills or frees itself on back pushes and pops.
// ----------------------------------------------------------------------------
module deq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  deq_pkg::cell_ctrl_type ctrl,
   input  deq_pkg::word_type      push_word,
   input  deq_pkg::word_type      left_word,
   input  logic                   left_occ,
   input  deq_pkg::word_type      right_word,
   input  logic                   right_occ,
   output deq_pkg::word_type      word_out,
   output logic                   occ_out,
   output deq_pkg::word_type      tail_word
);
   import deq_pkg::*;

   word_type word_ff, word_in;
   logic     occ_ff, occ_in;

   always_comb begin
      word_in = word_ff;
      occ_in  = occ_ff;
      if (ctrl.push_front) begin
         word_in = left_word;
         occ_in  = left_occ;
      end else if (ctrl.push_back) begin
         // first free cell takes the word
         if (!occ_ff && left_occ) begin
            word_in = push_word;
            occ_in  = 1'b1;
         end
      end else if (ctrl.pop_front) begin
         word_in = right_word;
         occ_in  = right_occ;
      end else if (ctrl.pop_back) begin
         if (occ_ff && !right_occ) begin
            occ_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out  = word_ff;
   assign occ_out   = occ_ff;
   assign tail_word = (occ_ff && !right_occ) ? word_ff : '0;

endmodule

/* hdl/double_ended_queue_core.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue built as a row of shifting storage cells.
// ----------------------------------------------------------------------------
// The queue keeps its words packed in a row of DEPTH cells, front word in the
// first cell. A front push or front pop shifts the whole row by one cell;
// a back push fills the first free cell and a back pop frees the last
// occupied one. The result of each accepted command is loaded into an output
// register at the same edge that updates the cell row and shows in the next
// cycle, so a command can be accepted on every clock as long as the previous
// result is taken in the same cycle. Pops on an empty queue and pushes on a
// full queue return a refusal status and change nothing.
module double_ended_queue_core (
   input logic  clock,
   input logic  reset,
   deq_req_if.sink   req_chan,
   deq_rsp_if.source rsp_chan
);
   import deq_pkg::*;

   cell_ctrl_type ctrl;
   word_type      push_word;
   word_type      cell_word [DEPTH];
   word_type      cell_tail [DEPTH];
   logic [DEPTH-1:0] cell_occ;
   word_type      tail_or;
   logic          full, empty, accept;
   status_type    status_cmd;
   word_type      pop_word;

   logic       rsp_valid_ff, rsp_valid_in;
   data_type   data_out_ff, data_out_in;
   status_type status_ff, status_in;
   count_type  count_ff, count_in;

   assign full      = cell_occ[DEPTH-1];
   assign empty     = !cell_occ[0];
   assign push_word = req_chan.data_in[STORE_W-1:0];
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept    = req_chan.valid && req_chan.ready;

   always_comb begin
      ctrl       = '0;
      status_cmd = ST_OK;
      case (req_chan.cmd)
         CMD_PUSH_FRONT: begin
            if (full) status_cmd = ST_FULL;
            else      ctrl.push_front = accept;
         end
         CMD_PUSH_BACK: begin
            if (full) status_cmd = ST_FULL;
            else      ctrl.push_back = accept;
         end
         CMD_POP_FRONT: begin
            if (empty) status_cmd = ST_EMPTY;
            else       ctrl.pop_front = accept;
         end
         CMD_POP_BACK: begin
            if (empty) status_cmd = ST_EMPTY;
            else       ctrl.pop_back = accept;
         end
         default: begin
            status_cmd = ST_OK;
         end
      endcase
   end

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         word_type lw, rw;
         logic     lo, ro;
         if (gi == 0) begin : g_head
            // the front cell sees the push word as its left neighbour
            assign lw = push_word;
            assign lo = 1'b1;
         end else begin : g_mid_l
            assign lw = cell_word[gi-1];
            assign lo = cell_occ[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_tail
            assign rw = '0;
            assign ro = 1'b0;
         end else begin : g_mid_r
            assign rw = cell_word[gi+1];
            assign ro = cell_occ[gi+1];
         end
         deq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .push_word  (push_word),
            .left_word  (lw),
            .left_occ   (lo),
            .right_word (rw),
            .right_occ  (ro),
            .word_out   (cell_word[gi]),
            .occ_out    (cell_occ[gi]),
            .tail_word  (cell_tail[gi])
         );
      end
   endgenerate

   // only the last occupied cell drives a non-zero tail word
   always_comb begin
      tail_or = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tail_or = tail_or | cell_tail[i];
      end
   end

   always_comb begin
      pop_word = '0;
      if (ctrl.pop_front) pop_word = cell_word[0];
      else if (ctrl.pop_back) pop_word = tail_or;
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.push_front || ctrl.push_back) count_in = count_ff + COUNT_W'(1);
      else if (ctrl.pop_front || ctrl.pop_back) count_in = count_ff - COUNT_W'(1);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept)              rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;
      data_out_in = accept ? DATA_W'(pop_word) : data_out_ff;
      status_in   = accept ? status_cmd : status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      data_out_ff <= data_out_in;
      status_ff   <= status_in;
   end

   // state only moves on a transfer, which also reloads the result register
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.data_out = data_out_ff;
   assign rsp_chan.status   = status_ff;
   assign rsp_chan.count    = count_ff;

   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) == $countones(cell_occ))
      else $error("count disagrees with occupied cells");

   a_cells_packed: assert property (@(posedge clock) disable iff (reset)
      ((cell_occ + DEPTH'(1)) & cell_occ) == '0)
      else $error("occupied cells not packed at the front");

   a_full_refusal: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == ST_FULL |-> 32'(rsp_chan.count) == DEPTH)
      else $error("full refusal with queue not full");

   a_empty_refusal: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == ST_EMPTY
         |-> rsp_chan.count == '0 && rsp_chan.data_out == '0)
      else $error("empty refusal with queue not empty");

endmodule

/* verif/tb_double_ended_queue_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue_core
// Self-checking bench for the double-ended queue: a short table of directed
// commands (empty pops, full pushes, zero and all-ones words, a fill to the
// top), then biased random command streams that swing the queue between
// empty and full. Each result is checked against its typed row or a shadow ring.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_core;
   import deq_pkg::*;

   localparam int PERIOD       = 4;
   localparam int RESET_CYCLES = 6;
   localparam int MAX_GAP      = 12;
   localparam int LONG_HOLD    = 300;
   localparam int RANDOM_ITEMS = 920;
   localparam int SETTLE       = 20;
   localparam int IDLE_LIMIT   = 2000;

   typedef struct packed {
      data_type   data_out;
      status_type status;
      count_type  count;
   } deq_result_type;

   typedef struct {
      cmd_type        cmd;
      data_type       data;
      bit             typed;
      deq_result_type result;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   deq_req_if req_bus ();
   deq_rsp_if rsp_bus ();

   double_ended_queue_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #(PERIOD / 2) clock = ~clock;

   // shadow ring
   word_type  ring_words [DEPTH];
   int        ring_front;
   int        ring_back;
   count_type ring_fill;

   deq_result_type pending_results [$];
   table_row_type  directed_rows [$];
   int             error_count   = 0;
   bit             hold_results  = 1'b0;
   int             send_burst    = 0;
   int             idle_cycles   = 0;

   function automatic int slot_after(int idx);
      return (idx == DEPTH - 1) ? 0 : idx + 1;
   endfunction

   function automatic int slot_before(int idx);
      return (idx == 0) ? DEPTH - 1 : idx - 1;
   endfunction

   function automatic deq_result_type apply_command(cmd_type cmd, data_type data);
      deq_result_type res;
      res = '{data_out: '0, status: ST_OK, count: '0};
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (ring_fill == count_type'(DEPTH)) begin
               res.status = ST_FULL;
            end else if (cmd == CMD_PUSH_FRONT) begin
               ring_front = slot_before(ring_front);
               ring_words[ring_front] = data[STORE_W-1:0];
               ring_fill++;
            end else begin
               ring_words[ring_back] = data[STORE_W-1:0];
               ring_back = slot_after(ring_back);
               ring_fill++;
            end
         end
         default: begin
            if (ring_fill == '0) begin
               res.status = ST_EMPTY;
            end else if (cmd == CMD_POP_FRONT) begin
               res.data_out = data_type'(ring_words[ring_front]);
               ring_front = slot_after(ring_front);
               ring_fill--;
            end else begin
               ring_back = slot_before(ring_back);
               res.data_out = data_type'(ring_words[ring_back]);
               ring_fill--;
            end
         end
      endcase
      res.count = ring_fill;
      return res;
   endfunction

   function automatic table_row_type make_row(cmd_type cmd, data_type data, bit typed,
                                              data_type exp_data, status_type exp_status,
                                              int exp_count);
      table_row_type row;
      row.cmd    = cmd;
      row.data   = data;
      row.typed  = typed;
      row.result = '{data_out: exp_data, status: exp_status, count: count_type'(exp_count)};
      return row;
   endfunction

   // one command transfer; the expectation is queued at the accepting edge
   task automatic offer_command(cmd_type cmd, data_type data, bit typed,
                                deq_result_type typed_result);
      int             gap;
      bit             taken;
      deq_result_type predicted;
      if (send_burst > 0) begin
         gap = 0;
         send_burst--;
      end else begin
         gap = $urandom_range(0, MAX_GAP);
         if ($urandom_range(0, 19) == 0) send_burst = 30;
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.cmd     <= cmd;
      req_bus.data_in <= data;
      do begin
         @(negedge clock);
         taken = req_bus.ready;
         @(posedge clock);
      end while (!taken);
      predicted = apply_command(cmd, data);
      pending_results.push_back(typed ? typed_result : predicted);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic data_type random_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return data_type'($urandom);
      endcase
   endfunction

   // stimulus
   initial begin : command_source
      int      push_pct;
      bit      push;
      bit      back;
      cmd_type cmd;

      req_bus.valid   = 1'b0;
      req_bus.cmd     = CMD_PUSH_FRONT;
      req_bus.data_in = '0;
      ring_words      = '{default: '0};
      ring_front      = 0;
      ring_back       = 0;
      ring_fill       = '0;

      directed_rows.push_back(make_row(CMD_POP_FRONT,  '0,           1, '0, ST_EMPTY, 0));
      directed_rows.push_back(make_row(CMD_POP_BACK,   '1,           1, '0, ST_EMPTY, 0));
      directed_rows.push_back(make_row(CMD_PUSH_FRONT, '1,           1, '0, ST_OK,    1));
      directed_rows.push_back(make_row(CMD_PUSH_BACK,  '0,           1, '0, ST_OK,    2));
      directed_rows.push_back(make_row(CMD_POP_BACK,   '0,           1, '0, ST_OK,    1));
      directed_rows.push_back(make_row(CMD_POP_FRONT,  '0,           1, '1, ST_OK,    0));
      directed_rows.push_back(make_row(CMD_POP_BACK,   '0,           1, '0, ST_EMPTY, 0));
      directed_rows.push_back(make_row(CMD_PUSH_BACK,  32'h8000_0000, 1, '0, ST_OK,   1));
      directed_rows.push_back(make_row(CMD_POP_FRONT,  '1,  1, 32'h8000_0000, ST_OK,  0));
      // fill to the top from both ends, wrapping the front index
      for (int i = 0; i < DEPTH; i++) begin
         directed_rows.push_back(make_row(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
                                          32'h0123_4567 * (i + 1), 0, '0, ST_OK, 0));
      end
      directed_rows.push_back(make_row(CMD_PUSH_FRONT, 32'h1234_5678, 1, '0, ST_FULL, DEPTH));
      directed_rows.push_back(make_row(CMD_PUSH_BACK,  '1,           1, '0, ST_FULL, DEPTH));
      directed_rows.push_back(make_row(CMD_POP_BACK,   '0,           0, '0, ST_OK,   0));
      directed_rows.push_back(make_row(CMD_POP_FRONT,  '0,           0, '0, ST_OK,   0));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         offer_command(directed_rows[i].cmd, directed_rows[i].data,
                       directed_rows[i].typed, directed_rows[i].result);
      end
      drain_results();

      push_pct = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // bias swings the fill level between empty and full
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0:       push_pct = 25;
               1:       push_pct = 50;
               default: push_pct = 75;
            endcase
         end
         if (n == 300) begin
            hold_results = 1'b1;
            send_burst   = 40;
         end
         if (n == 600) drain_results();
         push = ($urandom_range(0, 99) < push_pct);
         back = $urandom_range(0, 1);
         if (push) cmd = back ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
         else      cmd = back ? CMD_POP_BACK  : CMD_POP_FRONT;
         offer_command(cmd, random_word(), 0, '0);
      end
      drain_results();
      repeat (SETTLE) @(posedge clock);

      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // result side: random stalls, quiet stretches and one long hold-off
   initial begin : result_sink
      int             stall;
      int             quiet_run;
      bit             taken;
      deq_result_type got;
      deq_result_type want;

      quiet_run     = 0;
      rsp_bus.ready = 1'b0;
      do @(negedge clock); while (reset);
      @(posedge clock);
      forever begin
         if (hold_results) begin
            stall        = LONG_HOLD;
            hold_results = 1'b0;
         end else if (quiet_run > 0) begin
            stall = 0;
            quiet_run--;
         end else begin
            stall = $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 24) == 0) quiet_run = 40;
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do begin
            @(negedge clock);
            taken = rsp_bus.valid;
            got   = '{data_out: rsp_bus.data_out, status: rsp_bus.status,
                      count: rsp_bus.count};
            @(posedge clock);
         end while (!taken);

         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing pending: data %h status %0d count %0d",
                     $realtime, got.data_out, got.status, got.count);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.data_out !== want.data_out) begin
               $display("%0t: data_out expected %h actual %h",
                        $realtime, want.data_out, got.data_out);
               error_count++;
            end
            if (got.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $realtime, want.status, got.status);
               error_count++;
            end
            if (got.count !== want.count) begin
               $display("%0t: count expected %0d actual %0d",
                        $realtime, want.count, got.count);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(negedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

/* sim.f */
hdl/deq_pkg.sv
hdl/deq_req_if.sv
hdl/deq_rsp_if.sv
hdl/deq_cell.sv
hdl/double_ended_queue_core.sv
verif/tb_double_ended_queue_core.sv
